// ----- rtl/core/drrip_pkg.sv -----
// Shared constants, types and helpers for the DRRIP replacement core.
// No dependencies; every other file of the core uses this package.
`default_nettype none

package drrip_pkg;

  // Cache geometry and set-dueling layout.
  localparam int unsigned SETS        = 2048;
  localparam int unsigned SET_W       = 11;
  localparam int unsigned WAYS        = 16;
  localparam int unsigned WAY_W       = 4;
  localparam int unsigned LEADER_SETS = 64;
  localparam int unsigned DUEL_PERIOD = 512;

  // Field widths.
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned RR_W   = 2;
  localparam int unsigned SEL_W  = 10;
  localparam int unsigned CONF_W = 2;
  localparam int unsigned RND_W  = 5;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 24;

  // Re-reference and selector constants.
  localparam logic [RR_W-1:0]   RR_FAR   = 2'd3;
  localparam logic [RR_W-1:0]   RR_NEAR  = 2'd2;
  localparam logic [RR_W-1:0]   RR_HIT   = 2'd0;
  localparam logic [SEL_W-1:0]  SEL_MAX  = 10'd1023;
  localparam logic [SEL_W-1:0]  SEL_MID  = 10'd512;
  localparam logic [CONF_W-1:0] CONF_MAX = 2'd3;
  localparam logic [CONF_W-1:0] CONF_STREAM = 2'd2;

  // Item kinds carried on tuser.
  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // One stored row per set: all per-set state in one memory word.
  typedef struct packed {
    logic [RR_W*WAYS-1:0] rrv;
    logic [ADDR_W-1:0]    prev_addr;
    logic [ADDR_W-1:0]    last_stride;
    logic [CONF_W-1:0]    conf;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // Decoded input transaction.
  typedef struct packed {
    logic              action;
    logic [SET_W-1:0]  set_idx;
    logic [WAY_W-1:0]  way;
    logic [ADDR_W-1:0] address;
    logic              hit;
    logic [RND_W-1:0]  rnd;
  } item_t;

  // Result of one transaction.
  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic [RR_W-1:0]  inserted_value;
    logic             streaming;
    logic [SEL_W-1:0] selector_value;
  } result_t;

  // Value of a row right after reset.
  function automatic row_t reset_row();
    row_t r;
    r.rrv         = {WAYS{RR_FAR}};
    r.prev_addr   = '0;
    r.last_stride = '0;
    r.conf        = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/drrip_row_ram.sv -----
// Synchronous row memory holding all per-set replacement and stride state.
// One write and one read port, read data registered. Uses drrip_pkg.
`default_nettype none

module drrip_row_ram (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [drrip_pkg::SET_W-1:0]  waddr_i,
  input  drrip_pkg::row_t              wdata_i,
  input  wire                          re_i,
  input  wire  [drrip_pkg::SET_W-1:0]  raddr_i,
  output drrip_pkg::row_t              rdata_o
);

  drrip_pkg::row_t mem_q [drrip_pkg::SETS];
  drrip_pkg::row_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/drrip_row_update.sv -----
// Modify step of the read-modify-write: victim search with aging, stride
// detection, selector update and insertion. Purely combinational; uses drrip_pkg.
`default_nettype none

module drrip_row_update (
  input  drrip_pkg::item_t              item_i,
  input  drrip_pkg::row_t               row_i,
  input  wire  [drrip_pkg::SEL_W-1:0]   sel_i,
  output drrip_pkg::row_t               row_o,
  output wire  [drrip_pkg::SEL_W-1:0]   sel_o,
  output drrip_pkg::result_t            result_o
);

  logic [drrip_pkg::WAYS-1:0]       hi_bits;
  logic [drrip_pkg::WAYS-1:0]       lo_bits;
  logic [drrip_pkg::RR_W-1:0]       rr_max;
  logic [drrip_pkg::RR_W-1:0]       age_amt;
  logic [drrip_pkg::RR_W*drrip_pkg::WAYS-1:0] aged_rrv;
  logic [drrip_pkg::WAY_W-1:0]      victim;
  logic [drrip_pkg::SET_W-1:0]      duel_rem;
  logic                             srrip_leader;
  logic                             brrip_leader;
  logic [drrip_pkg::ADDR_W-1:0]     stride;
  logic                             stride_match;
  logic [drrip_pkg::CONF_W-1:0]     conf_next;
  logic                             strm;
  logic [drrip_pkg::SEL_W-1:0]      sel_next;
  logic                             bimodal_ins;
  logic [drrip_pkg::RR_W-1:0]       ins;
  logic                             way_ok;
  drrip_pkg::row_t                  row_upd;

  // Maximum re-reference value of the set, built from OR reductions.
  always_comb begin
    for (int w = 0; w < drrip_pkg::WAYS; w++) begin
      hi_bits[w] = row_i.rrv[w*drrip_pkg::RR_W + 1];
      lo_bits[w] = row_i.rrv[w*drrip_pkg::RR_W];
    end
    rr_max[1] = |hi_bits;
    rr_max[0] = rr_max[1] ? |(hi_bits & lo_bits) : |lo_bits;
    age_amt   = drrip_pkg::RR_FAR - rr_max;
  end

  // Age every way so that the oldest reaches the far value, then pick the
  // lowest way holding it.
  always_comb begin
    victim = '0;
    for (int w = 0; w < drrip_pkg::WAYS; w++) begin
      aged_rrv[w*drrip_pkg::RR_W +: drrip_pkg::RR_W] =
        row_i.rrv[w*drrip_pkg::RR_W +: drrip_pkg::RR_W] + age_amt;
    end
    for (int w = drrip_pkg::WAYS - 1; w >= 0; w--) begin
      if (aged_rrv[w*drrip_pkg::RR_W +: drrip_pkg::RR_W] == drrip_pkg::RR_FAR) begin
        victim = drrip_pkg::WAY_W'(w);
      end
    end
  end

  // Leader set classification.
  assign duel_rem     = item_i.set_idx % drrip_pkg::SET_W'(drrip_pkg::DUEL_PERIOD);
  assign srrip_leader = duel_rem < drrip_pkg::SET_W'(drrip_pkg::LEADER_SETS);
  assign brrip_leader = !srrip_leader &&
    (duel_rem >= drrip_pkg::SET_W'(drrip_pkg::DUEL_PERIOD - drrip_pkg::LEADER_SETS));

  // Stride detector with a saturating confidence counter.
  assign stride       = item_i.address - row_i.prev_addr;
  assign stride_match = (row_i.last_stride != '0) && (stride == row_i.last_stride);

  always_comb begin
    conf_next = row_i.conf;
    if (stride_match) begin
      if (row_i.conf != drrip_pkg::CONF_MAX) conf_next = row_i.conf + 1'b1;
    end else begin
      if (row_i.conf != '0) conf_next = row_i.conf - 1'b1;
    end
  end

  assign strm = conf_next >= drrip_pkg::CONF_STREAM;

  // Saturating policy selector, moved only by leader sets on updates.
  always_comb begin
    sel_next = sel_i;
    if (item_i.action == drrip_pkg::ACT_UPDATE) begin
      if (srrip_leader == item_i.hit && (srrip_leader || brrip_leader)) begin
        if (sel_i != drrip_pkg::SEL_MAX) sel_next = sel_i + 1'b1;
      end else if (srrip_leader || brrip_leader) begin
        if (sel_i != '0) sel_next = sel_i - 1'b1;
      end
    end
  end

  // Insertion value: promote on hit, far when streaming, else by policy.
  always_comb begin
    if (srrip_leader)      bimodal_ins = 1'b0;
    else if (brrip_leader) bimodal_ins = 1'b1;
    else                   bimodal_ins = sel_next < drrip_pkg::SEL_MID;

    if (item_i.hit) begin
      ins = drrip_pkg::RR_HIT;
    end else if (strm) begin
      ins = drrip_pkg::RR_FAR;
    end else if (bimodal_ins) begin
      ins = (item_i.rnd == '0) ? drrip_pkg::RR_NEAR : drrip_pkg::RR_FAR;
    end else begin
      ins = drrip_pkg::RR_NEAR;
    end
  end

  assign way_ok = {1'b0, item_i.way} < (drrip_pkg::WAY_W + 1)'(drrip_pkg::WAYS);

  // Row written back on an update.
  always_comb begin
    row_upd             = row_i;
    row_upd.prev_addr   = item_i.address;
    row_upd.last_stride = stride;
    row_upd.conf        = conf_next;
    if (way_ok) begin
      row_upd.rrv[item_i.way*drrip_pkg::RR_W +: drrip_pkg::RR_W] = ins;
    end
  end

  // Select between the query and update outcomes.
  always_comb begin
    if (item_i.action == drrip_pkg::ACT_QUERY) begin
      row_o                   = row_i;
      row_o.rrv               = aged_rrv;
      result_o.victim_way     = victim;
      result_o.inserted_value = '0;
      result_o.streaming      = 1'b0;
    end else begin
      row_o                   = row_upd;
      result_o.victim_way     = '0;
      result_o.inserted_value = ins;
      result_o.streaming      = strm;
    end
    result_o.selector_value = sel_next;
  end

  assign sel_o = sel_next;

endmodule

`default_nettype wire

// ----- rtl/core/drrip_replacement_with_stream_bypass_core.sv -----
// DRRIP replacement core with per-set stream bypass: top level with control,
// selector register and output register. Uses drrip_pkg, drrip_row_ram, drrip_row_update.
//
// Each transaction reads the set's row from the single row memory in the cycle it is
// accepted, then modifies and writes it back while loading the result register, once
// that register is empty or being read. One transaction is in flight at a time; a new one
// is accepted while a finished result still waits on the master side. After reset
// the core clears the row memory, one set per cycle, and holds s_axis_tready low
// until that pass is done. Queries age the set and return the lowest way at the
// far value; updates run the stride detector, move the set-dueling selector and
// write the insertion or promotion value.
`default_nettype none

module drrip_replacement_with_stream_bypass_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output wire                                  s_axis_tready,
  // set_index[10:0], way[14:11], address[78:15], hit[79], random_bits[84:80]
  input  wire  [drrip_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action[0]
  input  wire                                  s_axis_tuser,
  output wire                                  m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // victim_way[3:0], inserted_value[5:4], streaming[6], selector_value[16:7]
  output wire  [drrip_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RMW   = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [drrip_pkg::SET_W-1:0]   clr_q, clr_d;
  logic [drrip_pkg::SEL_W-1:0]   sel_q, sel_d;
  drrip_pkg::item_t              item_q;
  drrip_pkg::item_t              item_in;
  drrip_pkg::row_t               rd_row;
  drrip_pkg::row_t               wr_row;
  drrip_pkg::row_t               upd_row;
  drrip_pkg::result_t            res;
  drrip_pkg::result_t            res_q;
  logic                          out_valid_q, out_valid_d;
  logic                          in_fire;
  logic                          advance;
  logic                          ram_we;
  logic [drrip_pkg::SET_W-1:0]   ram_waddr;
  logic [drrip_pkg::SEL_W-1:0]   sel_upd;

  // Unpack the input transaction.
  assign item_in.action  = s_axis_tuser;
  assign item_in.set_idx = s_axis_tdata[10:0];
  assign item_in.way     = s_axis_tdata[14:11];
  assign item_in.address = s_axis_tdata[78:15];
  assign item_in.hit     = s_axis_tdata[79];
  assign item_in.rnd     = s_axis_tdata[84:80];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign advance       = (state_q == ST_RMW) && (!out_valid_q || m_axis_tready);

  // Control state, clear counter, selector and output valid.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == drrip_pkg::SET_W'(drrip_pkg::SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_RMW;
      end
      ST_RMW: begin
        if (advance) begin
          state_d     = ST_IDLE;
          sel_d       = sel_upd;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sel_q       <= drrip_pkg::SEL_MID;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the accepted transaction and the result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= item_in;
    if (advance) res_q <= res;
  end

  // Memory write: clearing pass or write-back of the modified row.
  assign ram_we    = (state_q == ST_CLEAR) || advance;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : item_q.set_idx;
  assign wr_row    = (state_q == ST_CLEAR) ? drrip_pkg::reset_row() : upd_row;

  drrip_row_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_row),
    .re_i    (in_fire),
    .raddr_i (item_in.set_idx),
    .rdata_o (rd_row)
  );

  drrip_row_update u_update (
    .item_i   (item_q),
    .row_i    (rd_row),
    .sel_i    (sel_q),
    .row_o    (upd_row),
    .sel_o    (sel_upd),
    .result_o (res)
  );

  // Pack the result transaction.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.selector_value, res_q.streaming,
                          res_q.inserted_value, res_q.victim_way};

  // No transaction is taken during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // An accepted transaction always moves to the modify cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RMW))
    else $error("accepted transaction did not reach modify cycle");

  // The selector moves only when a transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(sel_q))
    else $error("selector changed without a completing transaction");

  // A new result appears only right after a modify cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RMW))
    else $error("result valid without a modify cycle");

  // The selector steps by at most one per transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((sel_q == $past(sel_q)) || (sel_q == $past(sel_q) + 1'b1) ||
                 (sel_q == $past(sel_q) - 1'b1)))
    else $error("selector jumped by more than one");

endmodule

`default_nettype wire

// ----- tb/tb_drrip_replacement_with_stream_bypass_core.sv -----
// Self-checking testbench for the DRRIP replacement core with stream bypass.
// It depends on drrip_pkg and on the core's top level. It predicts every
// result inside the testbench and compares each output transaction with it.
`timescale 1ns / 1ps

module tb_drrip_replacement_with_stream_bypass_core;
  import drrip_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int POOL_SIZE    = 6;

  // Clock, reset and the two stream groups.
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  // set_index[10:0], way[14:11], address[78:15], hit[79], random_bits[84:80]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // action[0]
  logic                   s_axis_tuser = ACT_QUERY;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // victim_way[3:0], inserted_value[5:4], streaming[6], selector_value[16:7]
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;

  drrip_replacement_with_stream_bypass_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the per-set state and the dueling selector.
  logic [RR_W*WAYS-1:0] rrv_model    [SETS];
  logic [ADDR_W-1:0]    addr_model   [SETS];
  logic [ADDR_W-1:0]    stride_model [SETS];
  logic [CONF_W-1:0]    conf_model   [SETS];
  logic [SEL_W-1:0]     sel_model;

  result_t predicted_outcomes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int query_count    = 0;
  int update_count   = 0;
  int stream_count   = 0;
  int checked_count  = 0;
  int sel_lowest     = SEL_MID;
  int sel_highest    = SEL_MID;

  // Address walkers for a small pool of sets, so that strides repeat.
  int unsigned       pool_set  [POOL_SIZE];
  logic [ADDR_W-1:0] walk_addr [POOL_SIZE];
  logic [ADDR_W-1:0] walk_step [POOL_SIZE];

  // Computes the outcome of one transaction and advances the shadow state.
  function automatic result_t predict_replacement(item_t it);
    result_t           r;
    int                s;
    int                rem;
    logic [RR_W*WAYS-1:0] row;
    logic [RR_W-1:0]   peak;
    logic [ADDR_W-1:0] stride;
    logic              srrip_leader;
    logic              brrip_leader;
    logic              bimodal_ins;
    logic              found;
    r = '0;
    s = int'(it.set_idx) % SETS;
    rem = s % DUEL_PERIOD;
    srrip_leader = rem < LEADER_SETS;
    brrip_leader = !srrip_leader && (rem >= DUEL_PERIOD - LEADER_SETS);
    row = rrv_model[s];
    if (it.action == ACT_QUERY) begin
      // Age every way by the distance of the oldest one from far.
      peak = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (row[RR_W*w +: RR_W] > peak) peak = row[RR_W*w +: RR_W];
      end
      for (int w = 0; w < WAYS; w++) begin
        row[RR_W*w +: RR_W] = row[RR_W*w +: RR_W] + (RR_FAR - peak);
      end
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && row[RR_W*w +: RR_W] == RR_FAR) begin
          r.victim_way = WAY_W'(w);
          found = 1'b1;
        end
      end
    end else begin
      // Stride detector with a saturating confidence.
      stride = it.address - addr_model[s];
      if (stride_model[s] != '0 && stride == stride_model[s]) begin
        if (conf_model[s] < CONF_MAX) conf_model[s] = conf_model[s] + 1'b1;
      end else if (conf_model[s] != '0) begin
        conf_model[s] = conf_model[s] - 1'b1;
      end
      stride_model[s] = stride;
      addr_model[s] = it.address;
      r.streaming = conf_model[s] >= CONF_STREAM;
      // Leader sets steer the selector in opposite directions.
      if (srrip_leader) begin
        if (it.hit) begin
          if (sel_model != SEL_MAX) sel_model = sel_model + 1'b1;
        end else if (sel_model != '0) begin
          sel_model = sel_model - 1'b1;
        end
      end else if (brrip_leader) begin
        if (!it.hit) begin
          if (sel_model != SEL_MAX) sel_model = sel_model + 1'b1;
        end else if (sel_model != '0) begin
          sel_model = sel_model - 1'b1;
        end
      end
      // Promotion on a hit, bypass when streaming, else the chosen policy.
      if (it.hit) begin
        r.inserted_value = RR_HIT;
      end else if (r.streaming) begin
        r.inserted_value = RR_FAR;
      end else begin
        if (srrip_leader) bimodal_ins = 1'b0;
        else if (brrip_leader) bimodal_ins = 1'b1;
        else bimodal_ins = sel_model < SEL_MID;
        if (bimodal_ins) r.inserted_value = (it.rnd == '0) ? RR_NEAR : RR_FAR;
        else r.inserted_value = RR_NEAR;
      end
      row[RR_W*it.way +: RR_W] = r.inserted_value;
    end
    rrv_model[s] = row;
    r.selector_value = sel_model;
    return r;
  endfunction

  function automatic item_t make_item(logic action, int set_idx, int way,
                                      logic [ADDR_W-1:0] address, logic hit, int rnd);
    item_t it;
    it.action  = action;
    it.set_idx = SET_W'(set_idx);
    it.way     = WAY_W'(way);
    it.address = address;
    it.hit     = hit;
    it.rnd     = RND_W'(rnd);
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_step();
    case ($urandom_range(4))
      0: return 64'd64;
      1: return 64'd128;
      2: return 64'hFFFF_FFFF_FFFF_FFC0;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly traffic on a few sets with walking addresses, the rest anywhere.
  function automatic item_t random_access();
    item_t it;
    int    p;
    it.action  = ($urandom_range(99) < 40) ? ACT_QUERY : ACT_UPDATE;
    it.way     = WAY_W'($urandom_range(WAYS - 1));
    it.hit     = 1'($urandom_range(1));
    it.rnd     = ($urandom_range(3) == 0) ? '0 : RND_W'($urandom);
    it.address = {$urandom, $urandom};
    it.set_idx = SET_W'($urandom);
    if ($urandom_range(99) < 65) begin
      p = $urandom_range(POOL_SIZE - 1);
      it.set_idx = SET_W'(pool_set[p]);
      if (it.action == ACT_UPDATE) begin
        if ($urandom_range(99) < 80) begin
          if ($urandom_range(9) == 0) walk_step[p] = pick_step();
          walk_addr[p] = walk_addr[p] + walk_step[p];
          it.address = walk_addr[p];
        end else begin
          walk_addr[p] = it.address;
        end
      end
    end
    return it;
  endfunction

  // Offers one transaction, waits for its acceptance and records the outcome.
  task automatic send_access(input item_t it);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {3'b000, it.rnd, it.hit, it.address, it.way, it.set_idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_replacement(it);
    predicted_outcomes.push_back(r);
    if (it.action == ACT_QUERY) query_count++;
    else update_count++;
    if (r.streaming) stream_count++;
    if (r.selector_value < sel_lowest) sel_lowest = r.selector_value;
    if (r.selector_value > sel_highest) sel_highest = r.selector_value;
  endtask

  // One leader access that moves the selector up or down; some follower misses mixed in.
  task automatic send_duel_access(input logic upward);
    int   base;
    logic srrip_side;
    base = $urandom_range(SETS / DUEL_PERIOD - 1) * DUEL_PERIOD;
    srrip_side = 1'($urandom_range(1));
    if ($urandom_range(99) < 15) begin
      send_access(make_item(ACT_UPDATE,
                            base + $urandom_range(LEADER_SETS, DUEL_PERIOD - LEADER_SETS - 1),
                            $urandom_range(WAYS - 1), {$urandom, $urandom}, 1'b0,
                            $urandom_range(1) ? 0 : $urandom_range(31)));
    end else if (srrip_side) begin
      send_access(make_item(ACT_UPDATE, base + $urandom_range(LEADER_SETS - 1),
                            $urandom_range(WAYS - 1), {$urandom, $urandom}, upward,
                            $urandom_range(31)));
    end else begin
      send_access(make_item(ACT_UPDATE,
                            base + DUEL_PERIOD - LEADER_SETS + $urandom_range(LEADER_SETS - 1),
                            $urandom_range(WAYS - 1), {$urandom, $urandom}, !upward,
                            $urandom_range(31)));
    end
  endtask

  // Fresh sets pick way 0; a promoted way moves the victim on.
  task automatic test_reset_state();
    send_access(make_item(ACT_QUERY, 0, 0, '0, 1'b0, 0));
    send_access(make_item(ACT_QUERY, SETS - 1, WAYS - 1, '1, 1'b1, 31));
    send_access(make_item(ACT_UPDATE, 0, 0, '1, 1'b1, 31));
    send_access(make_item(ACT_QUERY, 0, 0, '0, 1'b0, 0));
  endtask

  // Insertion on both leader kinds and on followers at either side of the midpoint.
  task automatic test_insertion_policies();
    send_access(make_item(ACT_UPDATE, 511, 15, '0, 1'b0, 0));
    send_access(make_item(ACT_UPDATE, 1535, 3, 64'h1000, 1'b0, 31));
    send_access(make_item(ACT_UPDATE, 300, 7, 64'h2000, 1'b0, 17));
    send_access(make_item(ACT_UPDATE, 300, 7, 64'h2040, 1'b1, 17));
    send_access(make_item(ACT_QUERY, 300, 0, '0, 1'b0, 0));
    // Push the selector below the midpoint with SRRIP leader misses.
    for (int k = 0; k < 4; k++) begin
      send_access(make_item(ACT_UPDATE, 1 + k, k, 64'h3000 * (k + 1), 1'b0, 3));
    end
    send_access(make_item(ACT_UPDATE, 900, 9, 64'h4000, 1'b0, 0));
    send_access(make_item(ACT_UPDATE, 900, 10, 64'h8000, 1'b0, 9));
  endtask

  // A steady stride across the address wrap makes the set stream.
  task automatic test_stride_detector();
    send_access(make_item(ACT_UPDATE, SETS - 1, 1, 64'hFFFF_FFFF_FFFF_FF80, 1'b0, 5));
    send_access(make_item(ACT_UPDATE, SETS - 1, 2, 64'hFFFF_FFFF_FFFF_FFC0, 1'b0, 0));
    send_access(make_item(ACT_UPDATE, SETS - 1, 3, 64'd0, 1'b1, 0));
    send_access(make_item(ACT_UPDATE, SETS - 1, 4, 64'd64, 1'b0, 0));
    send_access(make_item(ACT_UPDATE, SETS - 1, 5, 64'd128, 1'b0, 12));
    send_access(make_item(ACT_UPDATE, SETS - 1, 6, 64'h5A5A_0000_1234_0000, 1'b0, 0));
    send_access(make_item(ACT_QUERY, SETS - 1, 0, '0, 1'b0, 0));
  endtask

  // Random traffic under each idling pattern in turn.
  task automatic test_random_traffic();
    int send_plan  [4] = '{0, 76, 0, 24};
    int stall_plan [4] = '{0, 0, 76, 24};
    pool_set[0] = $urandom_range(3) * DUEL_PERIOD + $urandom_range(LEADER_SETS - 1);
    pool_set[1] = $urandom_range(3) * DUEL_PERIOD + DUEL_PERIOD - 1 - $urandom_range(63);
    for (int p = 2; p < POOL_SIZE; p++) pool_set[p] = $urandom_range(SETS - 1);
    for (int p = 0; p < POOL_SIZE; p++) begin
      walk_addr[p] = {$urandom, $urandom};
      walk_step[p] = pick_step();
    end
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (RANDOM_ITEMS / 4) send_access(random_access());
    end
  endtask

  // Drive the selector down to its lower limit, hold it there, then step back up.
  task automatic test_selector_saturation();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    while (sel_model != '0) send_duel_access(1'b0);
    repeat (12) send_duel_access(1'b0);
    repeat (12) send_duel_access(1'b1);
  endtask

  // Result side: random stalls and a comparison of every output transaction.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.victim_way     = m_axis_tdata[3:0];
      got.inserted_value = m_axis_tdata[5:4];
      got.streaming      = m_axis_tdata[6];
      got.selector_value = m_axis_tdata[16:7];
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = predicted_outcomes.pop_front();
        checked_count++;
        if (got.victim_way !== want.victim_way) begin
          $display("%0t: victim_way expected %0d actual %0d",
                   $time, want.victim_way, got.victim_way);
          mismatch_count++;
        end
        if (got.inserted_value !== want.inserted_value) begin
          $display("%0t: inserted_value expected %0d actual %0d",
                   $time, want.inserted_value, got.inserted_value);
          mismatch_count++;
        end
        if (got.streaming !== want.streaming) begin
          $display("%0t: streaming expected %0d actual %0d",
                   $time, want.streaming, got.streaming);
          mismatch_count++;
        end
        if (got.selector_value !== want.selector_value) begin
          $display("%0t: selector_value expected %0d actual %0d",
                   $time, want.selector_value, got.selector_value);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, predicted_outcomes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SETS; s++) begin
      rrv_model[s]    = {WAYS{RR_FAR}};
      addr_model[s]   = '0;
      stride_model[s] = '0;
      conf_model[s]   = '0;
    end
    sel_model = SEL_MID;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_insertion_policies();
    test_stride_detector();
    test_random_traffic();
    test_selector_saturation();
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then allow for the core's latency.
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results: %0d queries, %0d updates, %0d streaming verdicts.",
             checked_count, query_count, update_count, stream_count);
    $display("Selector ranged from %0d to %0d under four idling patterns.",
             sel_lowest, sel_highest);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
